FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/gdh_pkg.sv
`timescale 1ns / 1ps

package gdh_pkg;

  // operation codes
  localparam logic [1:0] OP_ACCUM      = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_READ_CLEAR = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 2'd3;

  // bound reset values, q3.12
  localparam logic signed [15:0] X_LOW_RESET  = -16'sd12288;
  localparam logic signed [15:0] X_HIGH_RESET = 16'sd12288;
  localparam logic signed [15:0] Y_LOW_RESET  = -16'sd12288;
  localparam logic signed [15:0] Y_HIGH_RESET = 16'sd12288;

  localparam int unsigned COUNT_W = 32;

  // bin store access kinds
  localparam logic [1:0] KIND_INC   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic [7:0]         bin_row;
    logic [7:0]         bin_col;
  } cmd_t;

  typedef struct packed {
    logic               landed;
    logic [7:0]         hit_row;
    logic [7:0]         hit_col;
    logic [COUNT_W-1:0] bin_count;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
  } store_ctl_t;

endpackage

FILE: hdl/gdh_axis_div.sv
`timescale 1ns / 1ps

module gdh_axis_div #(
  parameter int GRID = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [15:0]              off,
  input  logic [15:0]              span,
  output logic                     done,
  output logic [$clog2(GRID)-1:0]  quo
);
  import gdh_pkg::*;

  localparam int IW   = $clog2(GRID);
  localparam int NW   = 16 + IW;
  localparam int CNTW = $clog2(IW + 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_LOAD = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;

  logic [1:0]      state;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   prod;
  logic [15:0]     rem;
  logic [IW-1:0]   low;
  logic [15:0]     dvs;
  logic [16:0]     trial;
  logic            ge;
  logic [15:0]     rem_next;

  // restoring step: bring in the next numerator bit
  assign trial    = {rem, low[IW-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign rem_next = ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            state <= D_LOAD;
          end
        end
        D_LOAD: begin
          state <= D_RUN;
          cnt   <= CNTW'(IW);
        end
        D_RUN: begin
          cnt <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            state <= D_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == D_IDLE && start) begin
      // off < span, so off * grid fits and the quotient stays below grid
      prod <= NW'(NW'(off) * NW'(GRID));
      dvs  <= span;
    end
    if (state == D_LOAD) begin
      rem <= prod[NW-1:IW];
      low <= prod[IW-1:0];
      quo <= '0;
    end
    if (state == D_RUN) begin
      rem <= rem_next;
      low <= low << 1;
      quo <= IW'({quo, ge});
    end
  end

endmodule

FILE: hdl/gdh_bin_store.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gdh_bin_store #(
  parameter int GRID = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  gdh_pkg::store_ctl_t                    ctl,
  input  logic [$clog2(GRID*GRID)-1:0]           addr,
  output logic                                   resp_valid,
  output logic [gdh_pkg::COUNT_W-1:0]            resp_count,
  output logic                                   clearing
);
  import gdh_pkg::*;

  localparam int DEPTH = GRID * GRID;
  localparam int AW    = $clog2(DEPTH);

  logic [COUNT_W-1:0] mem [DEPTH];

  logic [AW-1:0]      clr_addr;
  logic               pend;
  logic [1:0]         pend_kind;
  logic [AW-1:0]      pend_addr;
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] sat_inc;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [COUNT_W-1:0] wdata;
  logic [COUNT_W-1:0] count_next;

  assign sat_inc = (rd_data == '1) ? rd_data : rd_data + 1'b1;

  always_comb begin
    case (pend_kind)
      KIND_INC:   count_next = sat_inc;
      KIND_READ:  count_next = rd_data;
      KIND_CLEAR: count_next = rd_data;
      default:    count_next = '0;
    endcase
  end

  // clearing pass owns the write port until it ends
  assign we    = clearing || (pend && (pend_kind == KIND_INC || pend_kind == KIND_CLEAR));
  assign waddr = clearing ? clr_addr : pend_addr;
  assign wdata = (clearing || pend_kind != KIND_INC) ? '0 : sat_inc;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_addr   <= '0;
      pend       <= 1'b0;
      resp_valid <= 1'b0;
    end else begin
      pend       <= ctl.valid;
      resp_valid <= pend;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      pend_kind <= ctl.kind;
      pend_addr <= addr;
    end
    if (pend) begin
      resp_count <= count_next;
    end
  end

  // one access in flight at a time, never during the clearing pass
  `ASSERT_IMPLIES(a_req_when_free, clk, rst, ctl.valid, !clearing && !pend && !resp_valid)
  `ASSERT_IMPLIES(a_resp_has_req, clk, rst, resp_valid, $past(ctl.valid, 2))
  `ASSERT_NEXT(a_clear_ends_once, clk, rst, !clearing, !clearing)

endmodule

FILE: hdl/grid_density_histogram_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// two-dimensional density histogram over a GRID x GRID bin store. a command
// beat is taken when start is high and busy is low; every command gives one
// result beat, shown for a single cycle with done high, and the receiver
// cannot stall it. an accumulate passes through the eval step, the two
// bit-per-cycle axis dividers that run in parallel and the read-modify-write
// of the bin store; a read or read-and-clear goes from the eval step straight
// to the store, and a command that touches no bin leaves from the eval step.
// busy may drop in the cycle that done is high, so the next command can
// overlap the last result. after reset the store runs a clearing pass over
// all GRID * GRID bins with busy held high; configuration writes are taken
// at any time, but only while idle do they take effect cleanly.
module grid_density_histogram_unit #(
  parameter int GRID = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  gdh_pkg::cmd_t                     command,
  output logic                              done,
  output gdh_pkg::res_t                     result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gdh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);
  import gdh_pkg::*;

  localparam int IW    = $clog2(GRID);
  localparam int DEPTH = GRID * GRID;
  localparam int AW    = $clog2(DEPTH);
  // wide enough to hold GRID itself and any 8-bit read index
  localparam int CW    = ((IW > 8) ? IW : 8) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_MEM  = 2'd3;

  // bound registers
  logic signed [15:0] x_low, x_high, y_low, y_high;

  logic [1:0]  state;
  cmd_t        item;

  // axis offsets and spans, formed exactly in 17 bits
  logic signed [16:0] x_off, x_span, y_off, y_span;
  logic               x_ok, y_ok;
  logic               rd_in_grid;

  logic          div_start;
  logic          x_done, y_done;
  logic [IW-1:0] x_quo, y_quo;

  store_ctl_t        store_ctl;
  logic [AW-1:0]     store_addr;
  logic              resp_valid;
  logic [COUNT_W-1:0] resp_count;
  logic              clearing;

  // fields of the result waiting on the store
  logic       pend_landed;
  logic [7:0] pend_row;
  logic [7:0] pend_col;

  logic  emit_now;
  res_t  emit_res;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE) || clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low  <= X_LOW_RESET;
      x_high <= X_HIGH_RESET;
      y_low  <= Y_LOW_RESET;
      y_high <= Y_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_X_LOW:  x_low  <= cfg_data;
        CFG_X_HIGH: x_high <= cfg_data;
        CFG_Y_LOW:  y_low  <= cfg_data;
        CFG_Y_HIGH: y_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // point must sit in [low, high) on both axes, empty range counts nothing
  assign x_off  = {item.x_coord[15], item.x_coord} - {x_low[15], x_low};
  assign x_span = {x_high[15], x_high} - {x_low[15], x_low};
  assign y_off  = {item.y_coord[15], item.y_coord} - {y_low[15], y_low};
  assign y_span = {y_high[15], y_high} - {y_low[15], y_low};
  assign x_ok   = (x_span > 17'sd0) && (x_off >= 17'sd0) && (x_off < x_span);
  assign y_ok   = (y_span > 17'sd0) && (y_off >= 17'sd0) && (y_off < y_span);

  assign rd_in_grid = (CW'(item.bin_row) < CW'(GRID)) && (CW'(item.bin_col) < CW'(GRID));

  assign div_start = (state == S_EVAL) && (item.operation == OP_ACCUM) && x_ok && y_ok;

  gdh_axis_div #(.GRID(GRID)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .off   (x_off[15:0]),
    .span  (x_span[15:0]),
    .done  (x_done),
    .quo   (x_quo)
  );

  gdh_axis_div #(.GRID(GRID)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .off   (y_off[15:0]),
    .span  (y_span[15:0]),
    .done  (y_done),
    .quo   (y_quo)
  );

  // store request: bin update after the dividers, or a direct read or read-and-clear
  always_comb begin
    store_ctl.valid = 1'b0;
    store_ctl.kind  = KIND_READ;
    store_addr      = AW'(item.bin_row) * AW'(GRID) + AW'(item.bin_col);
    if (state == S_DIV && x_done) begin
      store_ctl.valid = 1'b1;
      store_ctl.kind  = KIND_INC;
      store_addr      = AW'(y_quo) * AW'(GRID) + AW'(x_quo);
    end else if (state == S_EVAL && rd_in_grid &&
                 (item.operation == OP_READ || item.operation == OP_READ_CLEAR)) begin
      store_ctl.valid = 1'b1;
      store_ctl.kind  = (item.operation == OP_READ_CLEAR) ? KIND_CLEAR : KIND_READ;
    end
  end

  // results that need no store access leave straight from the eval step, the rest when the store responds
  always_comb begin
    emit_now           = 1'b0;
    emit_res.landed    = 1'b0;
    emit_res.hit_row   = '0;
    emit_res.hit_col   = '0;
    emit_res.bin_count = '0;
    if (state == S_EVAL) begin
      case (item.operation)
        OP_ACCUM: begin
          emit_now = !(x_ok && y_ok);
        end
        OP_READ, OP_READ_CLEAR: begin
          emit_now         = !rd_in_grid;
          emit_res.hit_row = item.bin_row;
          emit_res.hit_col = item.bin_col;
        end
        default: begin
          // unused code: one all-zero beat
          emit_now = 1'b1;
        end
      endcase
    end else if (state == S_MEM && resp_valid) begin
      emit_now           = 1'b1;
      emit_res.landed    = pend_landed;
      emit_res.hit_row   = pend_row;
      emit_res.hit_col   = pend_col;
      emit_res.bin_count = resp_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= emit_now;
      case (state)
        S_IDLE: begin
          if (start && !busy) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (emit_now) begin
            state <= S_IDLE;
          end else if (div_start) begin
            state <= S_DIV;
          end else begin
            state <= S_MEM;
          end
        end
        S_DIV: begin
          if (x_done) begin
            state <= S_MEM;
          end
        end
        S_MEM: begin
          if (resp_valid) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && !busy) begin
      item <= command;
    end
    if (state == S_EVAL) begin
      pend_landed <= 1'b0;
      pend_row    <= item.bin_row;
      pend_col    <= item.bin_col;
    end
    if (state == S_DIV && x_done) begin
      pend_landed <= 1'b1;
      pend_row    <= 8'(y_quo);
      pend_col    <= 8'(x_quo);
    end
    if (emit_now) begin
      result <= emit_res;
    end
  end

  gdh_bin_store #(.GRID(GRID)) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (store_ctl),
    .addr       (store_addr),
    .resp_valid (resp_valid),
    .resp_count (resp_count),
    .clearing   (clearing)
  );

  // both axis dividers run in lockstep
  `ASSERT_IMPLIES(a_div_lockstep, clk, rst, x_done, y_done)
  // a result beat is never followed by another in the next cycle
  `ASSERT_NEXT(a_single_beat, clk, rst, done, !done)
  // an accepted beat holds busy until its result is produced
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

endmodule
